### rtl/ssrf_pkg.sv
// shared types, constants and helpers for the shadow stack return filter
package ssrf_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = 62;
  localparam int WORD_W      = 64;
  localparam int TAG_W       = 2;

  // result tags
  localparam logic [TAG_W-1:0] TAG_UNMATCHED = 2'd0;
  localparam logic [TAG_W-1:0] TAG_SPILL     = 2'd1;
  localparam logic [TAG_W-1:0] TAG_EVENT     = 2'd2;

  // operation codes; any other code behaves as a flush
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPILL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // source of an output word
  typedef enum logic {
    SRC_RDATA,
    SRC_ADDR
  } src_t;

  // input transaction
  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [WORD_W-1:0] forward_word;
    logic              last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic [TAG_W-1:0] tag;
    logic             wr_in;
    logic             wr_hold;
    logic             top_inc;
    logic             top_dec;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             rd_top;
    logic             rd_start;
    logic             rd_next;
    logic             load;
    src_t             src;
    logic             last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_one;
    logic out_free;
  } status_t;

  // ring pointer step forward
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(STACK_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  // ring pointer step back
  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) r = PTR_W'(STACK_DEPTH - 1);
    else r = p - PTR_W'(1);
    return r;
  endfunction

  // slot of the oldest entry: top minus count, modulo the depth
  function automatic logic [PTR_W-1:0] ptr_oldest(input logic [PTR_W-1:0] top,
                                                 input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] t;
    logic [CNT_W:0] c;
    logic [CNT_W:0] r;
    t = (CNT_W + 1)'(top);
    c = (CNT_W + 1)'(cnt);
    if (t >= c) r = t - c;
    else r = t + (CNT_W + 1)'(STACK_DEPTH) - c;
    return r[PTR_W-1:0];
  endfunction

endpackage

### rtl/ssrf_datapath.sv
// stack memory, pointers, entry count and output register
module ssrf_datapath
  import ssrf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  in_t     in_data,
  input  cmd_t    cmd,
  output status_t status,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  logic [ADDR_W-1:0] mem [STACK_DEPTH];
  logic [ADDR_W-1:0] rdata;
  logic [ADDR_W-1:0] addr_hold;
  logic [TAG_W-1:0]  tag_hold;
  logic [PTR_W-1:0]  top;
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  idx;
  logic [PTR_W-1:0]  idx_next;
  logic [PTR_W-1:0]  rd_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_data;
  logic              wr_en;
  logic [ADDR_W-1:0] load_addr;
  logic [TAG_W-1:0]  load_tag;
  logic              out_free;

  // status toward the controller
  assign out_free        = !out_valid || !out_stall;
  assign status.full     = (count == CNT_W'(STACK_DEPTH));
  assign status.empty    = (count == '0);
  assign status.cnt_one  = (count == CNT_W'(1));
  assign status.out_free = out_free;

  // read address select
  assign idx_next = ptr_inc(idx);
  assign rd_en    = cmd.rd_top || cmd.rd_start || cmd.rd_next;
  always_comb begin
    if (cmd.rd_start) rd_addr = ptr_oldest(top, count);
    else if (cmd.rd_next) rd_addr = idx_next;
    else rd_addr = top;
  end

  // write data select
  assign wr_en   = cmd.wr_in || cmd.wr_hold;
  assign wr_data = cmd.wr_in ? in_data.address : addr_hold;

  // stack memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[top] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // held transaction fields and drain index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_hold <= in_data.address;
      tag_hold  <= cmd.tag;
    end
    if (cmd.rd_start || cmd.rd_next) idx <= rd_addr;
  end

  // top pointer and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      count <= '0;
    end else begin
      if (cmd.top_inc) top <= ptr_inc(top);
      else if (cmd.top_dec) top <= ptr_dec(top);
      if (cmd.cnt_inc) count <= count + CNT_W'(1);
      else if (cmd.cnt_dec) count <= count - CNT_W'(1);
    end
  end

  // output word select
  always_comb begin
    case (cmd.src)
      SRC_RDATA: begin
        load_addr = rdata;
        load_tag  = TAG_SPILL;
      end
      SRC_ADDR: begin
        load_addr = addr_hold;
        load_tag  = tag_hold;
      end
      default: begin
        load_addr = addr_hold;
        load_tag  = tag_hold;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.forward_word <= {load_addr, load_tag};
      out_data.last         <= cmd.last;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> out_free)
    else $error("output register overwritten while pending");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> count != '0)
    else $error("entry count underflow");

  a_spill_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.top_inc && !cmd.cnt_inc) |-> status.full)
    else $error("spill write while stack not full");

endmodule

### rtl/ssrf_ctrl.sv
// controller state machine for the shadow stack return filter
module ssrf_ctrl
  import ssrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] operation,
  input  status_t    status,
  output logic       in_stall,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   take;

  assign take = in_valid && (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (operation)
            OP_PUSH: if (status.full) state_next = ST_SPILL;
            OP_POP:  if (status.empty) state_next = ST_EMIT;
            default: state_next = status.empty ? ST_EMIT : ST_DRAIN;
          endcase
        end
      end
      ST_SPILL: if (status.out_free) state_next = ST_IDLE;
      ST_DRAIN: if (status.out_free && status.cnt_one) state_next = ST_EMIT;
      ST_EMIT:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.src  = SRC_ADDR;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          cmd.tag    = (operation == OP_POP) ? TAG_UNMATCHED : TAG_EVENT;
          case (operation)
            OP_PUSH: begin
              if (status.full) begin
                cmd.rd_top = 1'b1;
              end else begin
                cmd.wr_in   = 1'b1;
                cmd.top_inc = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
            end
            OP_POP: begin
              if (!status.empty) begin
                cmd.top_dec = 1'b1;
                cmd.cnt_dec = 1'b1;
              end
            end
            default: begin
              if (!status.empty) cmd.rd_start = 1'b1;
            end
          endcase
        end
      end
      ST_SPILL: begin
        if (status.out_free) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_RDATA;
          cmd.last    = 1'b1;
          cmd.wr_hold = 1'b1;
          cmd.top_inc = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_RDATA;
          cmd.last    = 1'b0;
          cmd.cnt_dec = 1'b1;
          cmd.rd_next = !status.cnt_one;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          cmd.src  = SRC_ADDR;
          cmd.last = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // checks
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !in_stall && in_valid)
    else $error("transaction taken while busy");

  a_drain_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && status.out_free && status.cnt_one) |=> state == ST_EMIT)
    else $error("drain did not end in event result");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && !status.out_free) |=> $stable(state))
    else $error("state moved while output blocked");

endmodule

### rtl/shadow_stack_return_filter_core.sv
// top level of the shadow stack return filter
// A push or a pop on a non-empty stack yields no result, so such transactions
// can be taken every cycle. A push onto a full stack yields the spilled oldest
// entry; a pop on an empty stack yields its own address with tag 0. A flush or
// any other operation drains the live entries through the single stack memory
// read port, one entry per cycle while the output does not stall, oldest first,
// then the event word (tag 2, last) follows. No clearing pass is needed after
// reset.
module shadow_stack_return_filter_core
  import ssrf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t    cmd;
  status_t status;

  // control
  ssrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (in_data.operation),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // storage and output
  ssrf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/tb.sv
// testbench for the shadow stack return filter core with scoreboard and random traffic
`timescale 1ns / 1ps

module tb
  import ssrf_pkg::*;
();

  // operation code with no name of its own, behaves as a flush
  localparam logic [1:0] OP_OTHER = 2'd3;

  // all-ones and alternating address patterns
  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] ADDR_ALT_A = {(ADDR_W/2){2'b10}};
  localparam logic [ADDR_W-1:0] ADDR_ALT_B = {(ADDR_W/2){2'b01}};

  // predicts forwarded words from accepted events and checks them in order
  class forward_scoreboard;
    out_t              expected_words[$];
    logic [ADDR_W-1:0] shadow[STACK_DEPTH];
    int unsigned       top_slot;
    int unsigned       live;
    int                errors;

    function new();
      top_slot = 0;
      live     = 0;
      errors   = 0;
    endfunction

    function void add_word(logic [ADDR_W-1:0] addr, logic [TAG_W-1:0] tag, logic last);
      out_t w;
      w.forward_word = {addr, tag};
      w.last         = last;
      expected_words.push_back(w);
    endfunction

    // update the shadow copy of the stack and queue the words this event causes
    function void note_event(in_t ev);
      int unsigned idx;
      case (ev.operation)
        OP_PUSH: begin
          // full stack: the oldest entry sits in the slot about to be written
          if (live == STACK_DEPTH) add_word(shadow[top_slot], TAG_SPILL, 1'b1);
          else live++;
          shadow[top_slot] = ev.address;
          top_slot = (top_slot + 1) % STACK_DEPTH;
        end
        OP_POP: begin
          if (live == 0) begin
            add_word(ev.address, TAG_UNMATCHED, 1'b1);
          end else begin
            top_slot = (top_slot + STACK_DEPTH - 1) % STACK_DEPTH;
            live--;
          end
        end
        default: begin
          // drain oldest first, then the event word
          idx = (top_slot + STACK_DEPTH - live) % STACK_DEPTH;
          while (live > 0) begin
            add_word(shadow[idx], TAG_SPILL, 1'b0);
            idx = (idx + 1) % STACK_DEPTH;
            live--;
          end
          add_word(ev.address, TAG_EVENT, 1'b1);
        end
      endcase
    endfunction

    function void check_forward(out_t got);
      out_t want;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected transaction: actual word %h last %b",
                 $time, got.forward_word, got.last);
        errors++;
      end else begin
        // oldest expected word
        want = expected_words[0];
        expected_words.delete(0);
        if (got.forward_word !== want.forward_word) begin
          $display("%0t mismatch forward_word: expected %h actual %h",
                   $time, want.forward_word, got.forward_word);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t mismatch last: expected %b actual %b", $time, want.last, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int sender_idle_pct;
  int sink_stall_pct;

  forward_scoreboard sb;

  shadow_stack_return_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always #10 clk = ~clk;

  // result side: check accepted transactions and stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_forward(out_data);
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic in_t make_event(logic [1:0] op, logic [ADDR_W-1:0] addr);
    in_t ev;
    ev.operation = op;
    ev.address   = addr;
    return ev;
  endfunction

  // mostly random addresses, sometimes the extremes
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] raw;
    int          k;
    k   = $urandom_range(19);
    raw = {$urandom, $urandom};
    if (k == 0) raw = '0;
    else if (k == 1) raw = '1;
    return raw[ADDR_W-1:0];
  endfunction

  // present one event, with random idle cycles first, and wait until taken
  task automatic send_event(in_t ev);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(ev);
  endtask

  // hold the sender off until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  // call/return shaped traffic with some noise
  task automatic random_phase(int count);
    int sent;
    int k;
    int len;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(99);
      if (k < 40) begin
        // call burst, sometimes long enough to overflow the stack
        len = (k < 8) ? $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 8) : $urandom_range(1, 8);
        repeat (len) send_event(make_event(OP_PUSH, pick_address()));
        sent += len;
      end else if (k < 70) begin
        // return burst, may run past empty
        len = $urandom_range(1, 6);
        repeat (len) send_event(make_event(OP_POP, pick_address()));
        sent += len;
      end else if (k < 85) begin
        send_event(make_event(($urandom_range(1) != 0) ? OP_FLUSH : OP_OTHER, pick_address()));
        sent++;
      end else begin
        send_event(make_event(2'($urandom_range(3)), pick_address()));
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    sb              = new();
    clk             = 1'b0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty stack cases and field extremes
    send_event(make_event(OP_POP, '0));
    send_event(make_event(OP_POP, ADDR_ONES));
    send_event(make_event(OP_FLUSH, ADDR_ONES));
    send_event(make_event(OP_OTHER, '0));
    // pops on a non-empty stack leave nothing behind; the last pop finds it empty
    send_event(make_event(OP_PUSH, ADDR_ONES));
    send_event(make_event(OP_PUSH, '0));
    send_event(make_event(OP_POP, '0));
    send_event(make_event(OP_POP, ADDR_ALT_A));
    send_event(make_event(OP_POP, ADDR_ALT_B));
    // drain of several entries, oldest first
    send_event(make_event(OP_PUSH, ADDR_ALT_A));
    send_event(make_event(OP_PUSH, ADDR_ALT_B));
    send_event(make_event(OP_PUSH, ADDR_ONES));
    send_event(make_event(OP_FLUSH, ADDR_ALT_B));
    // unnamed opcode drains too
    send_event(make_event(OP_PUSH, ADDR_ALT_B));
    send_event(make_event(OP_OTHER, ADDR_ALT_A));
    // pop that does not match the top still removes it
    send_event(make_event(OP_PUSH, ADDR_ALT_A));
    send_event(make_event(OP_POP, ADDR_ALT_B));
    send_event(make_event(OP_POP, ADDR_ALT_A));
    drain_results();

    // random phases with different idle and stall mixes
    sender_idle_pct = 0;  sink_stall_pct = 0;
    random_phase(60);
    drain_results();
    sender_idle_pct = 52; sink_stall_pct = 0;
    random_phase(60);
    drain_results();
    sender_idle_pct = 0;  sink_stall_pct = 52;
    random_phase(60);
    drain_results();
    sender_idle_pct = 32; sink_stall_pct = 32;
    random_phase(60);
    // final flush empties the stack so everything comes out
    send_event(make_event(OP_FLUSH, pick_address()));
    in_valid <= 1'b0;

    // wait for outstanding words, then wait on for strays
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, sb.expected_words.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
